>>> src/kpsdc_pkg.sv
// Package for the keypad-set digital clock: shared types, codes and the row decoder.
// Used by kpsdc_ctrl, kpsdc_dpath and keypad_set_digital_clock; depends on nothing.
package kpsdc_pkg;

   localparam int ROW_W    = 12;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int KEY_W    = 4;
   localparam int WEIGHT_W = 10;
   localparam int TICK_W   = 16;
   localparam int NUM_ROWS = 4;
   localparam int NUM_COLS = 3;

   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 10'd1023;

   localparam logic [WEIGHT_W-1:0] HOLD_THRESHOLD_RESET   = 10'd500;
   localparam logic [TICK_W-1:0]   TICKS_PER_SECOND_RESET = 16'd1000;

   // Configuration register indexes
   localparam logic CSR_HOLD_THRESHOLD   = 1'b0;
   localparam logic CSR_TICKS_PER_SECOND = 1'b1;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_NONE        = 4'd0;
   localparam logic [KEY_W-1:0] KEY_HOUR_UP     = 4'd1;
   localparam logic [KEY_W-1:0] KEY_MINUTE_UP   = 4'd2;
   localparam logic [KEY_W-1:0] KEY_SECOND_UP   = 4'd3;
   localparam logic [KEY_W-1:0] KEY_HOUR_DOWN   = 4'd4;
   localparam logic [KEY_W-1:0] KEY_MINUTE_DOWN = 4'd5;
   localparam logic [KEY_W-1:0] KEY_SECOND_DOWN = 4'd6;
   localparam logic [KEY_W-1:0] KEY_IDLE_MARK   = 4'd12;

   localparam logic [KEY_W-1:0] KEY_CODES [NUM_ROWS][NUM_COLS] = '{
      '{4'd1,  4'd2, 4'd3},
      '{4'd4,  4'd5, 4'd6},
      '{4'd7,  4'd8, 4'd9},
      '{4'd10, 4'd0, 4'd11}
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_COUNT,
      ST_TICK_ADVANCE,
      ST_SCAN_DECODE,
      ST_SCAN_FIRE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch_in;
      logic tick_step;
      logic advance_time;
      logic scan_step;
      logic fire_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic second_due;
   } status_type;

   // One-hot rows decode to a key; later rows override earlier ones.
   function automatic logic [KEY_W-1:0] decode_keys(input logic [ROW_W-1:0] bits);
      logic [KEY_W-1:0] code;
      logic [NUM_COLS-1:0] col;
      code = KEY_NONE;
      for (int r = 0; r < NUM_ROWS; r++) begin
         col = bits[NUM_COLS*r +: NUM_COLS];
         case (col)
            3'b001:  code = KEY_CODES[r][0];
            3'b010:  code = KEY_CODES[r][1];
            3'b100:  code = KEY_CODES[r][2];
            default: code = code;
         endcase
      end
      return code;
   endfunction

endpackage

>>> src/keypad_set_digital_clock.sv
// Top level of the keypad-set digital clock: 24-hour clock set by a debounced keypad.
// Depends on kpsdc_pkg, kpsdc_ctrl and kpsdc_dpath.
//
//   group | dir | handshake             | payload
//   ------+-----+-----------------------+----------------------------------------------
//   req   | in  | req_tvalid/req_tready | tdata: row_bits; tuser: kind
//   rsp   | out | rsp_tvalid/rsp_tready | tdata: hours, minutes, seconds; tuser: refresh
//   csr   | in  | csr_valid/csr_ready   | csr_index: register, csr_data: value
//
// With the result side free, the controller walks idle, two work steps and a finish step
// for ticks and scans alike, and accepts the next item only once it is back in idle.
// Reset (synchronous) zeroes the time and tick count, clears key weights and loads the
// hold threshold with 500 and the ticks per second with 1000; no clearing pass is needed.
// A result waiting in the output register does not block work on the next item; only the
// finish step holds until rsp_tready frees the register. Configuration is always ready.
module keypad_set_digital_clock (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] row_bits, [15:12] zero
   input  logic        req_tuser,   // [0] kind: 0 tick, 1 keypad scan
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] hours, [10:5] minutes, [16:11] seconds, [23:17] zero
   output logic        rsp_tuser,   // [0] refresh
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,   // 0 hold_threshold, 1 ticks_per_second
   input  logic [15:0] csr_data
);

   kpsdc_pkg::cmd_type    cmd;
   kpsdc_pkg::status_type status;

   logic [kpsdc_pkg::HOUR_W-1:0]   rsp_hours;
   logic [kpsdc_pkg::MINUTE_W-1:0] rsp_minutes;
   logic [kpsdc_pkg::SECOND_W-1:0] rsp_seconds;

   // writes must land only while idle; the block itself does not enforce this, and csr_ready is tied high
   assign csr_ready = 1'b1;

   kpsdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kpsdc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .row_bits    (req_tdata[kpsdc_pkg::ROW_W-1:0]),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_hours   (rsp_hours),
      .rsp_minutes (rsp_minutes),
      .rsp_seconds (rsp_seconds),
      .rsp_refresh (rsp_tuser)
   );

   // pack the time fields, lowest first, padded to whole bytes
   assign rsp_tdata = {7'b0, rsp_seconds, rsp_minutes, rsp_hours};

endmodule

>>> src/kpsdc_ctrl.sv
// Controller for the keypad-set digital clock: sequences one item through the datapath.
// Depends on kpsdc_pkg (state, command and status types).
module kpsdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_kind,
   output logic                   req_tready,
   input  kpsdc_pkg::status_type  status,
   output kpsdc_pkg::cmd_type     cmd
);

   kpsdc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kpsdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         kpsdc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in = req_kind ? kpsdc_pkg::ST_SCAN_DECODE : kpsdc_pkg::ST_TICK_COUNT;
            end
         end
         kpsdc_pkg::ST_TICK_COUNT: begin
            cmd.tick_step = 1'b1;
            state_in = kpsdc_pkg::ST_TICK_ADVANCE;
         end
         kpsdc_pkg::ST_TICK_ADVANCE: begin
            // advance only when the count wrapped
            cmd.advance_time = status.second_due;
            state_in = kpsdc_pkg::ST_FINISH;
         end
         kpsdc_pkg::ST_SCAN_DECODE: begin
            cmd.scan_step = 1'b1;
            state_in = kpsdc_pkg::ST_SCAN_FIRE;
         end
         kpsdc_pkg::ST_SCAN_FIRE: begin
            cmd.fire_step = 1'b1;
            state_in = kpsdc_pkg::ST_FINISH;
         end
         kpsdc_pkg::ST_FINISH: begin
            // hold until the output register can take the item
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = kpsdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpsdc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/kpsdc_dpath.sv
// Datapath for the keypad-set digital clock: time, tick counter, key debounce, output register.
// Depends on kpsdc_pkg (widths, key codes, decoder, command and status types).
module kpsdc_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  kpsdc_pkg::cmd_type                 cmd,
   output kpsdc_pkg::status_type              status,
   input  logic [kpsdc_pkg::ROW_W-1:0]        row_bits,
   input  logic                               csr_valid,
   input  logic                               csr_index,
   input  logic [kpsdc_pkg::TICK_W-1:0]       csr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [kpsdc_pkg::HOUR_W-1:0]       rsp_hours,
   output logic [kpsdc_pkg::MINUTE_W-1:0]     rsp_minutes,
   output logic [kpsdc_pkg::SECOND_W-1:0]     rsp_seconds,
   output logic                               rsp_refresh
);

   logic [kpsdc_pkg::WEIGHT_W-1:0] threshold_ff, threshold_in;
   logic [kpsdc_pkg::TICK_W-1:0]   tps_ff, tps_in;
   logic [kpsdc_pkg::TICK_W-1:0]   tick_count_ff, tick_count_in;
   logic [kpsdc_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [kpsdc_pkg::MINUTE_W-1:0] minute_ff, minute_in;
   logic [kpsdc_pkg::SECOND_W-1:0] second_ff, second_in;
   logic [kpsdc_pkg::KEY_W-1:0]    last_key_ff, last_key_in;
   logic [kpsdc_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic                           pushed_ff, pushed_in;
   logic                           due_ff, due_in;
   logic                           refresh_ff, refresh_in;
   logic [kpsdc_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [kpsdc_pkg::HOUR_W-1:0]   rsp_hours_ff, rsp_hours_in;
   logic [kpsdc_pkg::MINUTE_W-1:0] rsp_minutes_ff, rsp_minutes_in;
   logic [kpsdc_pkg::SECOND_W-1:0] rsp_seconds_ff, rsp_seconds_in;
   logic                           rsp_refresh_ff, rsp_refresh_in;

   logic [kpsdc_pkg::TICK_W:0]     tick_next;
   logic                           tick_wrap;
   logic [kpsdc_pkg::KEY_W-1:0]    key;

   assign tick_next = {1'b0, tick_count_ff} + {{kpsdc_pkg::TICK_W{1'b0}}, 1'b1};
   assign tick_wrap = tick_next >= {1'b0, tps_ff};
   assign key       = kpsdc_pkg::decode_keys(row_ff);

   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;
   assign status.second_due = due_ff;

   always_comb begin
      threshold_in   = threshold_ff;
      tps_in         = tps_ff;
      tick_count_in  = tick_count_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      last_key_in    = last_key_ff;
      weight_in      = weight_ff;
      pushed_in      = pushed_ff;
      due_in         = due_ff;
      refresh_in     = refresh_ff;
      row_in         = row_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hours_in   = rsp_hours_ff;
      rsp_minutes_in = rsp_minutes_ff;
      rsp_seconds_in = rsp_seconds_ff;
      rsp_refresh_in = rsp_refresh_ff;

      if (csr_valid) begin
         case (csr_index)
            kpsdc_pkg::CSR_HOLD_THRESHOLD:   threshold_in = csr_data[kpsdc_pkg::WEIGHT_W-1:0];
            kpsdc_pkg::CSR_TICKS_PER_SECOND: tps_in = csr_data;
            default: tps_in = tps_ff;
         endcase
      end

      if (cmd.latch_in) begin
         row_in = row_bits;
      end

      if (cmd.tick_step) begin
         due_in        = tick_wrap;
         refresh_in    = tick_wrap;
         tick_count_in = tick_wrap ? '0 : tick_next[kpsdc_pkg::TICK_W-1:0];
      end

      // seconds carry into minutes, minutes into hours, wrap at midnight
      if (cmd.advance_time) begin
         if (second_ff == kpsdc_pkg::SECOND_MAX) begin
            second_in = '0;
            if (minute_ff == kpsdc_pkg::MINUTE_MAX) begin
               minute_in = '0;
               hour_in = (hour_ff == kpsdc_pkg::HOUR_MAX) ? '0 : hour_ff + 1'b1;
            end else begin
               minute_in = minute_ff + 1'b1;
            end
         end else begin
            second_in = second_ff + 1'b1;
         end
      end

      // only the current key can carry weight, so one weight and one flag suffice
      if (cmd.scan_step) begin
         last_key_in = key;
         if (key == last_key_ff) begin
            if (weight_ff != kpsdc_pkg::WEIGHT_MAX) begin
               weight_in = weight_ff + 1'b1;
            end
         end else begin
            weight_in = '0;
            pushed_in = 1'b0;
         end
      end

      if (cmd.fire_step) begin
         refresh_in = 1'b0;
         if (weight_ff > threshold_ff) begin
            weight_in = '0;
            pushed_in = !pushed_ff;
            if (!pushed_ff) begin
               refresh_in = 1'b1;
               case (last_key_ff)
                  kpsdc_pkg::KEY_HOUR_UP:
                     if (hour_ff < kpsdc_pkg::HOUR_MAX) hour_in = hour_ff + 1'b1;
                  kpsdc_pkg::KEY_HOUR_DOWN:
                     if (hour_ff != '0) hour_in = hour_ff - 1'b1;
                  kpsdc_pkg::KEY_MINUTE_UP:
                     if (minute_ff < kpsdc_pkg::MINUTE_MAX) minute_in = minute_ff + 1'b1;
                  kpsdc_pkg::KEY_MINUTE_DOWN:
                     if (minute_ff != '0) minute_in = minute_ff - 1'b1;
                  kpsdc_pkg::KEY_SECOND_UP:
                     if (second_ff < kpsdc_pkg::SECOND_MAX) second_in = second_ff + 1'b1;
                  kpsdc_pkg::KEY_SECOND_DOWN:
                     if (second_ff != '0) second_in = second_ff - 1'b1;
                  default: hour_in = hour_ff;
               endcase
            end
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_hours_in   = hour_ff;
         rsp_minutes_in = minute_ff;
         rsp_seconds_in = second_ff;
         rsp_refresh_in = refresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= kpsdc_pkg::HOLD_THRESHOLD_RESET;
         tps_ff        <= kpsdc_pkg::TICKS_PER_SECOND_RESET;
         tick_count_ff <= '0;
         hour_ff       <= '0;
         minute_ff     <= '0;
         second_ff     <= '0;
         last_key_ff   <= kpsdc_pkg::KEY_IDLE_MARK;
         weight_ff     <= '0;
         pushed_ff     <= 1'b0;
         due_ff        <= 1'b0;
         refresh_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         threshold_ff  <= threshold_in;
         tps_ff        <= tps_in;
         tick_count_ff <= tick_count_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         second_ff     <= second_in;
         last_key_ff   <= last_key_in;
         weight_ff     <= weight_in;
         pushed_ff     <= pushed_in;
         due_ff        <= due_in;
         refresh_ff    <= refresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      rsp_hours_ff   <= rsp_hours_in;
      rsp_minutes_ff <= rsp_minutes_in;
      rsp_seconds_ff <= rsp_seconds_in;
      rsp_refresh_ff <= rsp_refresh_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_hours   = rsp_hours_ff;
   assign rsp_minutes = rsp_minutes_ff;
   assign rsp_seconds = rsp_seconds_ff;
   assign rsp_refresh = rsp_refresh_ff;

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff <= kpsdc_pkg::HOUR_MAX && minute_ff <= kpsdc_pkg::MINUTE_MAX
      && second_ff <= kpsdc_pkg::SECOND_MAX)
      else $error("clock time left its range");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten before it was taken");

   a_wrap_clears_count: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_step && tick_wrap |=> tick_count_ff == '0 && due_ff)
      else $error("tick counter did not restart on a second boundary");

   a_fire_clears_weight: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_step && weight_ff > threshold_ff |=> weight_ff == '0)
      else $error("key weight not cleared after crossing the threshold");

endmodule
